>>> rtl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad and card code lock
// Event, mode, action, key and register codes, plus the configuration and
// result bundles passed between the lock modules.
// ----------------------------------------------------------------------------
package kcl_pkg;

	// Field widths fixed by the interface.
	localparam int UID_W     = 40;
	localparam int CODE_W    = 16;
	localparam int TRIES_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 40;

	// Default number of keys in one code entry.
	localparam int CODE_KEYS_DEF = 4;

	// Number of low UID bytes that take part in the card compare.
	localparam int UID_BYTES    = 5;
	localparam int UID_CMP_BITS = (8 * UID_BYTES >= UID_W) ? UID_W : 8 * UID_BYTES;
	localparam logic [UID_W-1:0] UID_MASK = {UID_W{1'b1}} >> (UID_W - UID_CMP_BITS);

	// Register reset values.
	localparam logic [UID_W-1:0]   CARD_UID_A_RST    = 40'hDB_7A9B_211B;
	localparam logic [UID_W-1:0]   CARD_UID_B_RST    = 40'h61_BBE4_2618;
	localparam logic [CODE_W-1:0]  RECOVERY_CODE_RST = 16'hACBD;
	localparam logic [CODE_W-1:0]  DEFAULT_CODE_RST  = 16'h0000;
	localparam logic [TRIES_W-1:0] MAX_WRONG_RST     = 3'd4;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CARD_UID_A    = 3'd0,
		CFG_CARD_UID_B    = 3'd1,
		CFG_RECOVERY_CODE = 3'd2,
		CFG_DEFAULT_CODE  = 3'd3,
		CFG_MAX_WRONG     = 3'd4
	} cfg_idx_t;

	// Input event kinds.
	typedef enum logic [1:0] {
		ACT_KEY       = 2'd0,
		ACT_CARD      = 2'd1,
		ACT_DOOR_BTN  = 2'd2,
		ACT_LOCK_BTN  = 2'd3
	} action_t;

	// Menu keys.
	localparam logic [3:0] KEY_A    = 4'd10;
	localparam logic [3:0] KEY_B    = 4'd11;
	localparam logic [3:0] KEY_C    = 4'd12;
	localparam logic [3:0] KEY_D    = 4'd13;
	localparam logic [3:0] KEY_STAR = 4'd14;
	localparam logic [3:0] KEY_HASH = 4'd15;

	// Result event codes.
	typedef enum logic [4:0] {
		EV_IGNORED     = 5'd0,
		EV_KEY_TAKEN   = 5'd1,
		EV_HELP        = 5'd2,
		EV_TO_IDLE     = 5'd3,
		EV_ENTRY_BEGUN = 5'd4,
		EV_MENU_CLOSE  = 5'd5,
		EV_CODE_RIGHT  = 5'd6,
		EV_CODE_WRONG  = 5'd7,
		EV_LOCKOUT     = 5'd8,
		EV_RECOVERY_OK = 5'd9,
		EV_RECOVERY_BAD= 5'd10,
		EV_OLD_OK      = 5'd11,
		EV_OLD_BAD     = 5'd12,
		EV_SAVED       = 5'd13,
		EV_CARD_OPEN   = 5'd14,
		EV_CARD_CLOSE  = 5'd15,
		EV_BAD_CARD    = 5'd16,
		EV_BTN_TOGGLE  = 5'd17,
		EV_MENU_ENTERED= 5'd18
	} event_t;

	// Door drive commands.
	typedef enum logic [1:0] {
		DOOR_NONE  = 2'd0,
		DOOR_OPEN  = 2'd1,
		DOOR_CLOSE = 2'd2
	} door_t;

	// Card holder codes.
	typedef enum logic [1:0] {
		HOLDER_NONE = 2'd0,
		HOLDER_A    = 2'd1,
		HOLDER_B    = 2'd2
	} holder_t;

	// Operating mode, one-hot.
	typedef enum logic [5:0] {
		MODE_IDLE     = 6'b000001,
		MODE_MENU     = 6'b000010,
		MODE_OPEN     = 6'b000100,
		MODE_RECOVERY = 6'b001000,
		MODE_OLD_CODE = 6'b010000,
		MODE_NEW_CODE = 6'b100000
	} mode_t;

	// Mode numbers as reported on the result channel.
	localparam logic [2:0] MODE_NUM_IDLE     = 3'd0;
	localparam logic [2:0] MODE_NUM_MENU     = 3'd1;
	localparam logic [2:0] MODE_NUM_OPEN     = 3'd2;
	localparam logic [2:0] MODE_NUM_RECOVERY = 3'd3;
	localparam logic [2:0] MODE_NUM_OLD_CODE = 3'd4;
	localparam logic [2:0] MODE_NUM_NEW_CODE = 3'd5;

	typedef struct packed {
		logic [UID_W-1:0]   card_uid_a;
		logic [UID_W-1:0]   card_uid_b;
		logic [CODE_W-1:0]  recovery_code;
		logic [CODE_W-1:0]  dflt_code;
		logic [TRIES_W-1:0] max_wrong;
	} kcl_cfg_t;

	typedef struct packed {
		event_t             ev;
		door_t              door;
		logic               beep;
		logic               alarm;
		logic [TRIES_W-1:0] wrong_tries;
		holder_t            holder;
		logic [2:0]         mode_num;
	} kcl_res_t;

	function automatic logic [2:0] mode_number(input mode_t m);
		logic [2:0] n;
		unique case (m)
			MODE_MENU:     n = MODE_NUM_MENU;
			MODE_OPEN:     n = MODE_NUM_OPEN;
			MODE_RECOVERY: n = MODE_NUM_RECOVERY;
			MODE_OLD_CODE: n = MODE_NUM_OLD_CODE;
			MODE_NEW_CODE: n = MODE_NUM_NEW_CODE;
			default:       n = MODE_NUM_IDLE;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/kcl_cfg_regs.sv
// ----------------------------------------------------------------------------
// kcl_cfg_regs: configuration registers of the code lock
// Holds the enrolled card UIDs, the recovery and default codes and the
// wrong-try limit; written through a simple indexed write port.
// ----------------------------------------------------------------------------
module kcl_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kcl_pkg::CFG_DAT_W-1:0]  cfg_data,
	output kcl_pkg::kcl_cfg_t              cfg
);

	kcl_pkg::kcl_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.card_uid_a    <= kcl_pkg::CARD_UID_A_RST;
			cfg_q.card_uid_b    <= kcl_pkg::CARD_UID_B_RST;
			cfg_q.recovery_code <= kcl_pkg::RECOVERY_CODE_RST;
			cfg_q.dflt_code     <= kcl_pkg::DEFAULT_CODE_RST;
			cfg_q.max_wrong     <= kcl_pkg::MAX_WRONG_RST;
		end else if (cfg_we) begin
			// Indexes past the last register are dropped.
			unique case (cfg_index)
				kcl_pkg::CFG_CARD_UID_A:
					cfg_q.card_uid_a <= cfg_data[kcl_pkg::UID_W-1:0];
				kcl_pkg::CFG_CARD_UID_B:
					cfg_q.card_uid_b <= cfg_data[kcl_pkg::UID_W-1:0];
				kcl_pkg::CFG_RECOVERY_CODE:
					cfg_q.recovery_code <= cfg_data[kcl_pkg::CODE_W-1:0];
				kcl_pkg::CFG_DEFAULT_CODE:
					cfg_q.dflt_code <= cfg_data[kcl_pkg::CODE_W-1:0];
				kcl_pkg::CFG_MAX_WRONG:
					cfg_q.max_wrong <= cfg_data[kcl_pkg::TRIES_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core: lock state and per-event decision logic
// Holds mode, code entry, stored code, wrong-try count and door toggles, and
// works out the result of one event in a single combinational pass.
// ----------------------------------------------------------------------------
module kcl_core #(
	parameter int CODE_KEYS = kcl_pkg::CODE_KEYS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [1:0]                 action,
	input  logic [3:0]                 key_code,
	input  logic [kcl_pkg::UID_W-1:0]  card_uid,
	input  kcl_pkg::kcl_cfg_t          cfg,
	output kcl_pkg::kcl_res_t          res
);

	localparam int EW    = 4 * CODE_KEYS;
	localparam int CNT_W = (CODE_KEYS > 1) ? $clog2(CODE_KEYS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_KEYS - 1);

	kcl_pkg::mode_t                mode_q, mode_n;
	logic [CNT_W-1:0]              cnt_q, cnt_n;
	logic [EW-1:0]                 buf_q, buf_n;
	logic [EW-1:0]                 stored_q, stored_n;
	logic [kcl_pkg::TRIES_W-1:0]   wrong_q, wrong_n;
	logic                          card_open_q, card_open_n;
	logic                          btn_closed_q, btn_closed_n;

	logic [EW+3:0]                 buf_cat;
	logic [EW-1:0]                 code;
	logic [EW+15:0]                rec_ext, dflt_ext;
	logic [EW-1:0]                 rec_fit, dflt_fit;
	logic                          entry_done;
	logic [kcl_pkg::UID_W-1:0]     uid_m;
	kcl_pkg::holder_t              holder;

	// Code registers are 16 bits; they are widened or cut to the entry width.
	assign rec_ext  = {{EW{1'b0}}, cfg.recovery_code};
	assign dflt_ext = {{EW{1'b0}}, cfg.dflt_code};
	assign rec_fit  = rec_ext[EW-1:0];
	assign dflt_fit = dflt_ext[EW-1:0];

	// The newest key shifts in at the low nibble.
	assign buf_cat    = {buf_q, key_code};
	assign code       = buf_cat[EW-1:0];
	assign entry_done = (cnt_q == CNT_LAST);

	assign uid_m = card_uid & kcl_pkg::UID_MASK;

	always_comb begin
		if (uid_m == (cfg.card_uid_a & kcl_pkg::UID_MASK))
			holder = kcl_pkg::HOLDER_A;
		else if (uid_m == (cfg.card_uid_b & kcl_pkg::UID_MASK))
			holder = kcl_pkg::HOLDER_B;
		else
			holder = kcl_pkg::HOLDER_NONE;
	end

	always_comb begin
		mode_n       = mode_q;
		cnt_n        = cnt_q;
		buf_n        = buf_q;
		stored_n     = stored_q;
		wrong_n      = wrong_q;
		card_open_n  = card_open_q;
		btn_closed_n = btn_closed_q;
		res.ev       = kcl_pkg::EV_IGNORED;
		res.door     = kcl_pkg::DOOR_NONE;
		res.beep     = 1'b0;
		res.alarm    = 1'b0;
		res.holder   = kcl_pkg::HOLDER_NONE;

		unique case (mode_q)
			kcl_pkg::MODE_MENU: begin
				if (action == kcl_pkg::ACT_KEY) begin
					cnt_n = '0;
					buf_n = '0;
					unique case (key_code)
						kcl_pkg::KEY_A: res.ev = kcl_pkg::EV_HELP;
						kcl_pkg::KEY_B: begin
							res.ev = kcl_pkg::EV_TO_IDLE;
							mode_n = kcl_pkg::MODE_IDLE;
						end
						kcl_pkg::KEY_C: begin
							res.ev = kcl_pkg::EV_ENTRY_BEGUN;
							mode_n = kcl_pkg::MODE_RECOVERY;
						end
						kcl_pkg::KEY_D: begin
							res.ev   = kcl_pkg::EV_MENU_CLOSE;
							res.door = kcl_pkg::DOOR_CLOSE;
							res.beep = 1'b1;
						end
						kcl_pkg::KEY_STAR: begin
							res.ev = kcl_pkg::EV_ENTRY_BEGUN;
							mode_n = kcl_pkg::MODE_OPEN;
						end
						kcl_pkg::KEY_HASH: begin
							res.ev = kcl_pkg::EV_ENTRY_BEGUN;
							mode_n = kcl_pkg::MODE_OLD_CODE;
						end
						default: ;
					endcase
				end
			end

			kcl_pkg::MODE_OPEN, kcl_pkg::MODE_RECOVERY,
			kcl_pkg::MODE_OLD_CODE, kcl_pkg::MODE_NEW_CODE: begin
				if (action == kcl_pkg::ACT_KEY) begin
					res.beep = 1'b1;
					if (!entry_done) begin
						res.ev = kcl_pkg::EV_KEY_TAKEN;
						cnt_n  = cnt_q + 1'b1;
						buf_n  = code;
					end else begin
						cnt_n  = '0;
						buf_n  = '0;
						mode_n = kcl_pkg::MODE_MENU;
						unique case (mode_q)
							kcl_pkg::MODE_OPEN: begin
								if (code == stored_q) begin
									res.ev   = kcl_pkg::EV_CODE_RIGHT;
									res.door = kcl_pkg::DOOR_OPEN;
									wrong_n  = '0;
								end else if (wrong_q >= cfg.max_wrong) begin
									res.ev    = kcl_pkg::EV_LOCKOUT;
									res.alarm = 1'b1;
									wrong_n   = '0;
								end else begin
									res.ev  = kcl_pkg::EV_CODE_WRONG;
									wrong_n = wrong_q + 1'b1;
								end
							end
							kcl_pkg::MODE_RECOVERY: begin
								if (code == rec_fit) begin
									res.ev   = kcl_pkg::EV_RECOVERY_OK;
									stored_n = dflt_fit;
								end else begin
									res.ev = kcl_pkg::EV_RECOVERY_BAD;
								end
							end
							kcl_pkg::MODE_OLD_CODE: begin
								if (code == stored_q) begin
									res.ev = kcl_pkg::EV_OLD_OK;
									mode_n = kcl_pkg::MODE_NEW_CODE;
								end else begin
									res.ev = kcl_pkg::EV_OLD_BAD;
								end
							end
							default: begin
								res.ev   = kcl_pkg::EV_SAVED;
								stored_n = code;
							end
						endcase
					end
				end
			end

			default: begin
				// Idle, and any code that cannot arise, behave as idle.
				mode_n = kcl_pkg::MODE_IDLE;
				unique case (action)
					kcl_pkg::ACT_CARD: begin
						res.holder = holder;
						if (holder != kcl_pkg::HOLDER_NONE) begin
							res.beep    = 1'b1;
							card_open_n = !card_open_q;
							if (!card_open_q) begin
								res.ev   = kcl_pkg::EV_CARD_OPEN;
								res.door = kcl_pkg::DOOR_OPEN;
							end else begin
								res.ev   = kcl_pkg::EV_CARD_CLOSE;
								res.door = kcl_pkg::DOOR_CLOSE;
							end
						end else begin
							res.ev    = kcl_pkg::EV_BAD_CARD;
							res.alarm = 1'b1;
						end
					end
					kcl_pkg::ACT_DOOR_BTN: begin
						res.ev       = kcl_pkg::EV_BTN_TOGGLE;
						res.beep     = 1'b1;
						btn_closed_n = !btn_closed_q;
						res.door     = btn_closed_q ? kcl_pkg::DOOR_OPEN : kcl_pkg::DOOR_CLOSE;
					end
					kcl_pkg::ACT_LOCK_BTN: begin
						res.ev = kcl_pkg::EV_MENU_ENTERED;
						mode_n = kcl_pkg::MODE_MENU;
						cnt_n  = '0;
						buf_n  = '0;
					end
					default: ;
				endcase
			end
		endcase

		res.wrong_tries = wrong_n;
		res.mode_num    = kcl_pkg::mode_number(mode_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= kcl_pkg::MODE_IDLE;
			cnt_q        <= '0;
			buf_q        <= '0;
			stored_q     <= '0;
			wrong_q      <= '0;
			card_open_q  <= 1'b0;
			btn_closed_q <= 1'b0;
		end else if (step) begin
			mode_q       <= mode_n;
			cnt_q        <= cnt_n;
			buf_q        <= buf_n;
			stored_q     <= stored_n;
			wrong_q      <= wrong_n;
			card_open_q  <= card_open_n;
			btn_closed_q <= btn_closed_n;
		end
	end

	// A partial entry only exists while a code is being typed.
	a_cnt_only_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (mode_q != kcl_pkg::MODE_IDLE && mode_q != kcl_pkg::MODE_MENU))
		else $error("key count left over outside code entry");

	a_buf_only_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(buf_q != '0) |-> (mode_q != kcl_pkg::MODE_IDLE && mode_q != kcl_pkg::MODE_MENU))
		else $error("entry buffer left over outside code entry");

	a_alarm_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.alarm) |-> (res.ev == kcl_pkg::EV_LOCKOUT || res.ev == kcl_pkg::EV_BAD_CARD))
		else $error("alarm raised without lockout or unknown card");

endmodule

>>> rtl/keypad_rfid_code_lock_unit.sv
// ----------------------------------------------------------------------------
// keypad_rfid_code_lock_unit: keypad and card reader door lock controller
// Takes keypad, card and button events and reports one result per event.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the input channel (in_valid/in_ready) carries one event:
// a key press, a card UID read, a door-button press or a lock-button press.
// For every event exactly one result leaves on the output channel
// (out_valid/out_ready), in order, with the event outcome, the door drive
// command, beep and alarm requests, the wrong-try count, the card holder
// and the mode after the event.
// An event passes the input register, then one pass of the decision logic
// into the result register. Throughput is one event per cycle while the
// receiver takes results; the lock state in kcl_core updates once per event.
// When the receiver stalls, the result register holds its transfer and an
// empty input register still takes one more event; after that in_ready drops
// until the result is taken. Configuration writes on cfg_we/cfg_index/
// cfg_data take effect once registered and are meant for an idle block.
// Reset puts the lock in idle with an all-zero stored code, zero wrong
// tries, both door toggles cleared and the registers at their defaults.
// ----------------------------------------------------------------------------
module keypad_rfid_code_lock_unit #(
	parameter int CODE_KEYS = kcl_pkg::CODE_KEYS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_we,
	input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kcl_pkg::CFG_DAT_W-1:0] cfg_data,

	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [3:0]                    key_code,
	input  logic [kcl_pkg::UID_W-1:0]     card_uid,

	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [4:0]                    event_res,
	output logic [1:0]                    door_command,
	output logic                          beep,
	output logic                          alarm,
	output logic [kcl_pkg::TRIES_W-1:0]   wrong_tries,
	output logic [1:0]                    card_holder,
	output logic [2:0]                    mode_now
);

	kcl_pkg::kcl_cfg_t cfg;
	kcl_pkg::kcl_res_t res;
	kcl_pkg::kcl_res_t res_s2;

	logic                      valid_s1;
	logic                      valid_s2;
	logic [1:0]                action_s1;
	logic [3:0]                key_s1;
	logic [kcl_pkg::UID_W-1:0] uid_s1;
	logic                      advance;
	logic                      step;

	// The result register can load whenever it is empty or being drained.
	assign advance  = !valid_s2 || out_ready;
	// The input register frees up whenever its event moves on.
	assign in_ready = !valid_s1 || advance;
	// An event is processed, and the lock state updated, exactly once.
	assign step     = valid_s1 && advance;

	kcl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			key_s1    <= key_code;
			uid_s1    <= card_uid;
		end
	end

	kcl_core #(
		.CODE_KEYS (CODE_KEYS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.action   (action_s1),
		.key_code (key_s1),
		.card_uid (uid_s1),
		.cfg      (cfg),
		.res      (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign event_res    = res_s2.ev;
	assign door_command = res_s2.door;
	assign beep         = res_s2.beep;
	assign alarm        = res_s2.alarm;
	assign wrong_tries  = res_s2.wrong_tries;
	assign card_holder  = res_s2.holder;
	assign mode_now     = res_s2.mode_num;

	// An accepted event must be sitting in the input register next cycle.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted event lost before the input register");

	// A stalled result stays up with its payload unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(res_s2)))
		else $error("stalled result dropped or changed");

	// An empty input register always takes a new event.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input refused while the input register is empty");

endmodule
